// ===== rtl/spq_pkg.sv =====
// spq_pkg: shared types, command and status codes for the sorted priority queue.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

  localparam int ELEMENT_BITS     = 16;
  localparam int PRIORITY_BITS    = 16;
  localparam int COUNT_BITS       = 7;
  localparam int CAPACITY_DEFAULT = 64;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_QUERY   = 2'd2;
  // unused code, behaves as a query
  localparam logic [1:0] CMD_SPARE   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]               command;
    logic [ELEMENT_BITS-1:0]  element;
    logic [PRIORITY_BITS-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    logic [ELEMENT_BITS-1:0]  front_element;
    logic [PRIORITY_BITS-1:0] front_priority;
    logic [COUNT_BITS-1:0]    count;
    logic                     is_empty;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic [ELEMENT_BITS-1:0]  element;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  // broadcast to every cell for one accepted item
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t entry;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/sorted_priority_queue_unit.sv =====
// sorted_priority_queue_unit: top level, a row of spq_cell slots kept sorted.
// Depends on spq_pkg and spq_cell.
//
//   channel | ports                     | direction | payload
//   input   | in_valid/in_ready/in_item | in        | spq_pkg::in_item_t
//   result  | out_valid/out_ready/out_item | out    | spq_pkg::out_item_t
//
// One item per cycle unless stalled: all slots compare and shift in parallel.
// The result is registered and appears in the cycle after acceptance.
// A new item is taken whenever the output register is empty or being drained.
// Reset (rst_n low, synchronous) empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  spq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  wire                out_ready,
  output spq_pkg::out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             accept;
  logic             full;
  logic             is_empty;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     entries [CAPACITY];
  logic                at_vec  [CAPACITY];

  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign is_empty = (count_r == '0);

  always_comb begin
    ctrl.enq         = accept && (in_item.command == spq_pkg::CMD_ENQUEUE) && !full;
    ctrl.deq         = accept && (in_item.command == spq_pkg::CMD_DEQUEUE) && !is_empty;
    ctrl.entry.element = in_item.element;
    ctrl.entry.prio    = in_item.priority_req;
  end

  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
      status_nxt    = spq_pkg::ST_OK;
      case (in_item.command)
        spq_pkg::CMD_ENQUEUE: begin
          if (full) begin
            status_nxt = spq_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        spq_pkg::CMD_DEQUEUE: begin
          if (is_empty) begin
            status_nxt = spq_pkg::ST_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        default: begin
          status_nxt = spq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= spq_pkg::ST_OK;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_at;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_at    = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign left_at    = at_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = entries[i];
    end else begin : g_mid
      assign right_entry = entries[i+1];
    end

    spq_cell #(
      .INDEX (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (count_r),
      .left_entry  (left_entry),
      .left_at     (left_at),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .at          (at_vec[i])
    );
  end

  // queue is frozen while the result waits, so the head slot is read directly
  always_comb begin
    out_item.front_element  = is_empty ? '0 : entries[0].element;
    out_item.front_priority = is_empty ? '0 : entries[0].prio;
    out_item.count          = spq_pkg::COUNT_BITS'(count_r);
    out_item.is_empty       = is_empty;
    out_item.status         = status_r;
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/spq_cell.sv =====
// spq_cell: one slot of the sorted shift array.
// Depends on spq_pkg; instantiated in a row by sorted_priority_queue_unit.
`timescale 1ns / 1ps
`default_nettype none
module spq_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  wire                 clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  wire [CNT_W-1:0]     count,
  input  spq_pkg::entry_t     left_entry,
  input  wire                 left_at,
  input  spq_pkg::entry_t     right_entry,
  output spq_pkg::entry_t     entry,
  output logic                at
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // new item lands at or before this slot
  assign at = (CNT_W'(INDEX) >= count) || (entry_r.prio > ctrl.entry.prio);

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.enq && at) begin
      entry_nxt = left_at ? left_entry : ctrl.entry;
    end else if (ctrl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

// ===== rtl/spq_checker.sv =====
// spq_checker: port-level assertions for sorted_priority_queue_unit.
// Depends on spq_pkg; attached to the top level by the bind at the end.
`timescale 1ns / 1ps
`default_nettype none
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_ready,
  input spq_pkg::in_item_t  in_item,
  input wire                out_valid,
  input wire                out_ready,
  input spq_pkg::out_item_t out_item
);

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.is_empty == (out_item.count == '0)) &&
                   (!out_item.is_empty ||
                    (out_item.front_element == '0 && out_item.front_priority == '0))))
    else $error("is_empty or front disagrees with count");

  a_status_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == spq_pkg::ST_EMPTY) |-> out_item.is_empty)
    else $error("empty status on non-empty queue");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == spq_pkg::ST_FULL) |->
      (out_item.count == spq_pkg::COUNT_BITS'(CAPACITY)))
    else $error("full status with spare room");

  a_enq_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_item.command == spq_pkg::CMD_ENQUEUE) |=>
      (out_valid && (out_item.status == spq_pkg::ST_FULL || !out_item.is_empty)))
    else $error("enqueue item left queue empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled item changed");

endmodule

bind sorted_priority_queue_unit spq_checker #(
  .CAPACITY (CAPACITY)
) u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
